// ----- hw/rtl/rotated_quad_vertex_expander_macros.svh -----
// Assertion macros used by the back end of the rotated quad vertex expander RTL.
`ifndef ROTATED_QUAD_VERTEX_EXPANDER_MACROS_SVH
`define ROTATED_QUAD_VERTEX_EXPANDER_MACROS_SVH
`ifndef ASSERT_OFF
// Implication check, disabled during reset.
`define RQVE_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");
// Next-cycle implication check, disabled during reset.
`define RQVE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define RQVE_ASSERT_IMPLY(label, clk, rst, pre, post)
`define RQVE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- hw/rtl/rqve_pkg.sv -----
// Types, constants and helper functions of the rotated quad vertex expander.
package rqve_pkg;

   localparam int CoordWidth    = 16;
   localparam int AngleWidth    = 16;
   localparam int ColorWidth    = 32;
   localparam int TexRectWidth  = 64;
   localparam int TexWidth      = 16;
   localparam int IndexWidth    = 11;
   localparam int SumWidth      = CoordWidth + 1;
   localparam int TrigWidth     = 33;
   localparam int ZWidth        = 34;
   localparam int ProdWidth     = SumWidth + TrigWidth;
   localparam int AccWidth      = ProdWidth + 3;
   localparam int FracShift     = 30;
   localparam int RoundShift    = 31;
   localparam int VertsPerQuad  = 6;

   localparam logic signed [TrigWidth-1:0] CordicStart = 33'sd652032874;
   localparam logic signed [TrigWidth-1:0] TrigOne     = 33'sd1073741824;
   localparam logic signed [17:0]          HalfTurn    = 18'sd32768;

   typedef struct packed {
      logic signed [CoordWidth-1:0] left_x;
      logic signed [CoordWidth-1:0] top_y;
      logic signed [CoordWidth-1:0] right_x;
      logic signed [CoordWidth-1:0] bottom_y;
      logic [AngleWidth-1:0]        turn_angle;
      logic [ColorWidth-1:0]        rgba_color;
      logic [TexRectWidth-1:0]      main_tex_rect;
      logic [TexRectWidth-1:0]      detail_tex_rect;
      logic [IndexWidth-1:0]        base_index;
      logic                         overflow;
   } quad_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ROTATE,
      BACK_PRODUCT,
      BACK_EMIT
   } back_state_type;

   function automatic logic signed [ZWidth-1:0] cordic_atan(input logic [3:0] i);
      logic signed [ZWidth-1:0] r;
      unique case (i)
         4'd0:  r = 34'sd536870912;
         4'd1:  r = 34'sd316933406;
         4'd2:  r = 34'sd167458907;
         4'd3:  r = 34'sd85004756;
         4'd4:  r = 34'sd42667331;
         4'd5:  r = 34'sd21354465;
         4'd6:  r = 34'sd10679838;
         4'd7:  r = 34'sd5340245;
         4'd8:  r = 34'sd2670163;
         4'd9:  r = 34'sd1335087;
         4'd10: r = 34'sd667544;
         4'd11: r = 34'sd333772;
         4'd12: r = 34'sd166886;
         4'd13: r = 34'sd83443;
         4'd14: r = 34'sd41722;
         4'd15: r = 34'sd20861;
      endcase
      return r;
   endfunction

   // Corner choice of the six vertices p00, p10, p11, p00, p11, p01.
   function automatic logic corner_x(input logic [2:0] k);
      return (k == 3'd1) || (k == 3'd2) || (k == 3'd4);
   endfunction

   function automatic logic corner_y(input logic [2:0] k);
      return (k == 3'd2) || (k == 3'd4) || (k == 3'd5);
   endfunction

   // Round half up, drop the fraction and saturate to the coordinate range.
   function automatic logic signed [CoordWidth-1:0] finish_coord(
      input logic signed [AccWidth-1:0] acc);
      logic signed [AccWidth-1:0] v;
      logic signed [CoordWidth-1:0] r;
      v = (acc + (AccWidth'(1) <<< FracShift)) >>> RoundShift;
      if (v > AccWidth'(32767))
         r = 16'sh7fff;
      else if (v < -AccWidth'(32768))
         r = 16'sh8000;
      else
         r = v[CoordWidth-1:0];
      return r;
   endfunction

endpackage

// ----- hw/rtl/rqve_front.sv -----
// Front end: accepts quads, runs the batch capacity check and index base.
module rqve_front #(
   parameter int VertexCapacity = 2048
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [rqve_pkg::CoordWidth-1:0] req_left_x,
   input  logic signed [rqve_pkg::CoordWidth-1:0] req_top_y,
   input  logic signed [rqve_pkg::CoordWidth-1:0] req_right_x,
   input  logic signed [rqve_pkg::CoordWidth-1:0] req_bottom_y,
   input  logic [rqve_pkg::AngleWidth-1:0]        req_turn_angle,
   input  logic [rqve_pkg::ColorWidth-1:0]        req_rgba_color,
   input  logic [rqve_pkg::TexRectWidth-1:0]      req_main_tex_rect,
   input  logic [rqve_pkg::TexRectWidth-1:0]      req_detail_tex_rect,
   input  logic                                   req_last_quad,
   output logic                                   push_valid,
   input  logic                                   push_ready,
   output rqve_pkg::quad_type                     push_data
);
   localparam int CountWidth = $clog2(VertexCapacity + 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  seen_ff, seen_in;
   logic                  accept, fits, ovf;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign fits = ({1'b0, count_ff} + (CountWidth + 1)'(rqve_pkg::VertsPerQuad))
                 <= (CountWidth + 1)'(VertexCapacity);
   assign ovf  = seen_ff || !fits;

   always_comb begin
      push_data.left_x          = req_left_x;
      push_data.top_y           = req_top_y;
      push_data.right_x         = req_right_x;
      push_data.bottom_y        = req_bottom_y;
      push_data.turn_angle      = req_turn_angle;
      push_data.rgba_color      = req_rgba_color;
      push_data.main_tex_rect   = req_main_tex_rect;
      push_data.detail_tex_rect = req_detail_tex_rect;
      push_data.base_index      = rqve_pkg::IndexWidth'(count_ff);
      push_data.overflow        = ovf;
   end

   always_comb begin
      count_in = count_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (req_last_quad) begin
            count_in = '0;
            seen_in  = 1'b0;
         end else begin
            seen_in = ovf;
            if (fits)
               count_in = count_ff + CountWidth'(rqve_pkg::VertsPerQuad);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end
endmodule

// ----- hw/rtl/rqve_queue.sv -----
// Two-entry queue between the front and back ends.
module rqve_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rqve_pkg::quad_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rqve_pkg::quad_type pop_data
);
   rqve_pkg::quad_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] used_ff;
   logic       do_push, do_pop;

   assign push_ready = (used_ff != 2'd2);
   assign pop_valid  = (used_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         if (do_push)
            wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)
            rd_ptr_ff <= !rd_ptr_ff;
         if (do_push && !do_pop)
            used_ff <= used_ff + 2'd1;
         else if (do_pop && !do_push)
            used_ff <= used_ff - 2'd1;
      end
   end
endmodule

// ----- hw/rtl/rqve_back.sv -----
// Back end: CORDIC sine/cosine, corner products and six-vertex emission.
`include "rotated_quad_vertex_expander_macros.svh"
module rqve_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   pop_valid,
   output logic                                   pop_ready,
   input  rqve_pkg::quad_type                     pop_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rqve_pkg::CoordWidth-1:0] rsp_pos_x,
   output logic signed [rqve_pkg::CoordWidth-1:0] rsp_pos_y,
   output logic [rqve_pkg::ColorWidth-1:0]        rsp_vertex_color,
   output logic [rqve_pkg::TexWidth-1:0]          rsp_tex_u,
   output logic [rqve_pkg::TexWidth-1:0]          rsp_tex_v,
   output logic [rqve_pkg::TexWidth-1:0]          rsp_detail_u,
   output logic [rqve_pkg::TexWidth-1:0]          rsp_detail_v,
   output logic [rqve_pkg::IndexWidth-1:0]        rsp_buffer_slot,
   output logic                                   rsp_last_vertex,
   output logic                                   rsp_overflow
);
   localparam int TW = rqve_pkg::TrigWidth;
   localparam int ZW = rqve_pkg::ZWidth;
   localparam int PW = rqve_pkg::ProdWidth;
   localparam int AW = rqve_pkg::AccWidth;
   localparam int SW = rqve_pkg::SumWidth;
   localparam int CW = rqve_pkg::CoordWidth;
   localparam int TXW = rqve_pkg::TexWidth;

   rqve_pkg::back_state_type state_ff, state_in;
   rqve_pkg::quad_type       item_ff, item_in;
   logic signed [TW-1:0] x_ff, x_in, y_ff, y_in, c_ff, c_in, s_ff, s_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 flip_ff, flip_in;
   logic [2:0]           step_ff, step_in, vert_ff, vert_in;
   logic signed [PW-1:0] pdc_ff, pes_ff, pds_ff, pec_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]       pos_x_ff, pos_y_ff;
   logic [rqve_pkg::ColorWidth-1:0] color_ff;
   logic [TXW-1:0]             tex_u_ff, tex_v_ff, det_u_ff, det_v_ff;
   logic [rqve_pkg::IndexWidth-1:0] index_ff;
   logic                       last_ff, ovf_ff;

   logic load_out, take;
   logic [15:0] angle;
   logic [1:0]  quarter;
   logic signed [17:0] za;
   logic signed [SW-1:0] d_x, d_y, sum_x, sum_y;
   logic cx, cy;
   logic signed [PW-1:0] tx1, tx2, ty1, ty2;
   logic signed [AW-1:0] acc_x, acc_y;
   logic signed [TW-1:0] xr, yr, xsh, ysh;
   logic signed [ZW-1:0] zr;
   logic [3:0] iter;

   assign pop_ready = (state_ff == rqve_pkg::BACK_IDLE);
   assign take      = pop_valid && pop_ready;
   assign load_out  = (state_ff == rqve_pkg::BACK_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign angle     = pop_data.turn_angle;
   assign quarter   = angle[15:14];

   // Offsets and sums of the held quad.
   assign d_x   = SW'(item_ff.left_x) - SW'(item_ff.right_x);
   assign d_y   = SW'(item_ff.top_y) - SW'(item_ff.bottom_y);
   assign sum_x = SW'(item_ff.left_x) + SW'(item_ff.right_x);
   assign sum_y = SW'(item_ff.top_y) + SW'(item_ff.bottom_y);
   assign cx    = rqve_pkg::corner_x(vert_ff);
   assign cy    = rqve_pkg::corner_y(vert_ff);

   always_comb begin
      tx1   = cx ? -pdc_ff : pdc_ff;
      tx2   = cy ? -pes_ff : pes_ff;
      ty1   = cx ? -pds_ff : pds_ff;
      ty2   = cy ? -pec_ff : pec_ff;
      acc_x = (AW'(sum_x) <<< rqve_pkg::FracShift) + AW'(tx1) - AW'(tx2);
      acc_y = (AW'(sum_y) <<< rqve_pkg::FracShift) + AW'(ty1) + AW'(ty2);
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      c_in     = c_ff;
      s_in     = s_ff;
      flip_in  = flip_ff;
      step_in  = step_ff;
      vert_in  = vert_ff;
      xr       = x_ff;
      yr       = y_ff;
      zr       = z_ff;
      xsh      = '0;
      ysh      = '0;
      iter     = '0;
      za       = 18'(signed'(angle));
      unique case (state_ff)
         rqve_pkg::BACK_IDLE: begin
            if (take) begin
               item_in = pop_data;
               if (angle[13:0] == 14'd0) begin
                  unique case (quarter)
                     2'd0: begin c_in = rqve_pkg::TrigOne;  s_in = '0; end
                     2'd1: begin c_in = '0; s_in = rqve_pkg::TrigOne;  end
                     2'd2: begin c_in = -rqve_pkg::TrigOne; s_in = '0; end
                     2'd3: begin c_in = '0; s_in = -rqve_pkg::TrigOne; end
                  endcase
                  state_in = rqve_pkg::BACK_PRODUCT;
               end else begin
                  flip_in = (quarter == 2'd1) || (quarter == 2'd2);
                  if (flip_in)
                     za = (za > 18'sd0) ? za - rqve_pkg::HalfTurn : za + rqve_pkg::HalfTurn;
                  z_in     = ZW'(za) <<< 16;
                  x_in     = rqve_pkg::CordicStart;
                  y_in     = '0;
                  step_in  = '0;
                  state_in = rqve_pkg::BACK_ROTATE;
               end
            end
         end
         rqve_pkg::BACK_ROTATE: begin
            // Two micro-rotations per cycle.
            for (int j = 0; j < 2; j++) begin
               iter = {step_ff, j[0]};
               xsh  = xr >>> iter;
               ysh  = yr >>> iter;
               if (zr >= 0) begin
                  xr = xr - ysh;
                  yr = yr + xsh;
                  zr = zr - rqve_pkg::cordic_atan(iter);
               end else begin
                  xr = xr + ysh;
                  yr = yr - xsh;
                  zr = zr + rqve_pkg::cordic_atan(iter);
               end
            end
            x_in    = xr;
            y_in    = yr;
            z_in    = zr;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               c_in     = flip_ff ? -xr : xr;
               s_in     = flip_ff ? -yr : yr;
               state_in = rqve_pkg::BACK_PRODUCT;
            end
         end
         rqve_pkg::BACK_PRODUCT: begin
            vert_in  = '0;
            state_in = rqve_pkg::BACK_EMIT;
         end
         rqve_pkg::BACK_EMIT: begin
            if (load_out) begin
               vert_in = vert_ff + 3'd1;
               if (vert_ff == 3'(rqve_pkg::VertsPerQuad - 1))
                  state_in = rqve_pkg::BACK_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqve_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         vert_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         vert_ff      <= vert_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      c_ff    <= c_in;
      s_ff    <= s_in;
      flip_ff <= flip_in;
      if (state_ff == rqve_pkg::BACK_PRODUCT) begin
         pdc_ff <= PW'(d_x) * PW'(c_ff);
         pes_ff <= PW'(d_y) * PW'(s_ff);
         pds_ff <= PW'(d_x) * PW'(s_ff);
         pec_ff <= PW'(d_y) * PW'(c_ff);
      end
      if (load_out) begin
         pos_x_ff <= rqve_pkg::finish_coord(acc_x);
         pos_y_ff <= rqve_pkg::finish_coord(acc_y);
         color_ff <= item_ff.rgba_color;
         tex_u_ff <= cx ? item_ff.main_tex_rect[47:32] : item_ff.main_tex_rect[15:0];
         tex_v_ff <= cy ? item_ff.main_tex_rect[63:48] : item_ff.main_tex_rect[31:16];
         det_u_ff <= cx ? item_ff.detail_tex_rect[47:32] : item_ff.detail_tex_rect[15:0];
         det_v_ff <= cy ? item_ff.detail_tex_rect[63:48] : item_ff.detail_tex_rect[31:16];
         index_ff <= item_ff.base_index + rqve_pkg::IndexWidth'(vert_ff);
         last_ff  <= (vert_ff == 3'(rqve_pkg::VertsPerQuad - 1));
         ovf_ff   <= item_ff.overflow;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_vertex_color = color_ff;
   assign rsp_tex_u        = tex_u_ff;
   assign rsp_tex_v        = tex_v_ff;
   assign rsp_detail_u     = det_u_ff;
   assign rsp_detail_v     = det_v_ff;
   assign rsp_buffer_slot  = index_ff;
   assign rsp_last_vertex  = last_ff;
   assign rsp_overflow     = ovf_ff;

   `RQVE_ASSERT_IMPLY(a_emit_count, clock, reset,
      state_ff == rqve_pkg::BACK_EMIT, vert_ff <= 3'd5)
   `RQVE_ASSERT_NEXT(a_last_to_idle, clock, reset,
      load_out && vert_ff == 3'd5, state_ff == rqve_pkg::BACK_IDLE)
   `RQVE_ASSERT_NEXT(a_product_to_emit, clock, reset, state_ff == rqve_pkg::BACK_PRODUCT,
      state_ff == rqve_pkg::BACK_EMIT && vert_ff == 3'd0)
endmodule

// ----- hw/rtl/rotated_quad_vertex_expander.sv -----
// Top level of the rotated quad vertex expander: front, queue and back end.
//
//   channel   direction  transaction
//   req_*     in         one quad: corners, angle, color, two texture rects, last flag
//   rsp_*     out        one vertex: position, color, texture coords, slot, flags
//
// When its angle is not an exact quarter turn, a quad holds the back end through
// a load, the CORDIC rotation at two micro-rotations each step, a product step and
// the emission of six vertices; exact quarter turns skip the rotation. The next quad
// loads in the cycle after the sixth vertex. A vertex waiting on rsp_ready holds it longer.
// The iterative CORDIC sets the rate. Reset is synchronous, active high, and
// clears the batch counter, the overflow flag and all valid state. The two-entry
// queue lets the front accept up to two quads while the back end is busy or stalled.
module rotated_quad_vertex_expander #(
   parameter int VertexCapacity = 2048
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [rqve_pkg::CoordWidth-1:0] req_left_x,
   input  logic signed [rqve_pkg::CoordWidth-1:0] req_top_y,
   input  logic signed [rqve_pkg::CoordWidth-1:0] req_right_x,
   input  logic signed [rqve_pkg::CoordWidth-1:0] req_bottom_y,
   input  logic [rqve_pkg::AngleWidth-1:0]        req_turn_angle,
   input  logic [rqve_pkg::ColorWidth-1:0]        req_rgba_color,
   input  logic [rqve_pkg::TexRectWidth-1:0]      req_main_tex_rect,
   input  logic [rqve_pkg::TexRectWidth-1:0]      req_detail_tex_rect,
   input  logic                                   req_last_quad,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [rqve_pkg::CoordWidth-1:0] rsp_pos_x,
   output logic signed [rqve_pkg::CoordWidth-1:0] rsp_pos_y,
   output logic [rqve_pkg::ColorWidth-1:0]        rsp_vertex_color,
   output logic [rqve_pkg::TexWidth-1:0]          rsp_tex_u,
   output logic [rqve_pkg::TexWidth-1:0]          rsp_tex_v,
   output logic [rqve_pkg::TexWidth-1:0]          rsp_detail_u,
   output logic [rqve_pkg::TexWidth-1:0]          rsp_detail_v,
   output logic [rqve_pkg::IndexWidth-1:0]        rsp_buffer_slot,
   output logic                                   rsp_last_vertex,
   output logic                                   rsp_overflow
);
   // Classified quads travel front to back through the queue.
   logic               push_valid, push_ready, pop_valid, pop_ready;
   rqve_pkg::quad_type push_data, pop_data;

   // Front: check capacity, stamp the index base and overflow flag.
   rqve_front #(.VertexCapacity(VertexCapacity)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_left_x(req_left_x), .req_top_y(req_top_y),
      .req_right_x(req_right_x), .req_bottom_y(req_bottom_y),
      .req_turn_angle(req_turn_angle), .req_rgba_color(req_rgba_color),
      .req_main_tex_rect(req_main_tex_rect), .req_detail_tex_rect(req_detail_tex_rect),
      .req_last_quad(req_last_quad),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
   );

   // Hold up to two quads so each side stalls on its own.
   rqve_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   // Back: rotate and emit the six vertices through a registered output.
   rqve_back u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_vertex_color(rsp_vertex_color),
      .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v),
      .rsp_detail_u(rsp_detail_u), .rsp_detail_v(rsp_detail_v),
      .rsp_buffer_slot(rsp_buffer_slot),
      .rsp_last_vertex(rsp_last_vertex), .rsp_overflow(rsp_overflow)
   );
endmodule
